// ----- hdl/cdra_pkg.sv -----
// ----------------------------------------------------------------------------
// cdra_pkg
// Types, constants and the arctangent table shared by the dead-reckoning
// accumulator modules.
// ----------------------------------------------------------------------------
package cdra_pkg;

  // field widths
  localparam int unsigned BEARING_W = 16;
  localparam int unsigned DIST_W    = 24;
  localparam int unsigned STEP_W    = 25;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned THR_W     = 8;

  // shared multiplier
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // cordic datapath: vector Q40.24 trimmed to what it can reach, angle 32-bit binary
  localparam int unsigned CX_W   = 44;
  localparam int unsigned CZ_W   = 34;
  localparam int unsigned ANG_W  = 32;
  localparam int unsigned X0_W   = 40;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned RND_W  = 29;

  // bearing to binary angle: 2^32 = 36000 * 119304 + 23296
  localparam logic [BEARING_W-1:0] BEARING_WRAP = 16'd36000;
  localparam logic [MUL_W-1:0]     ANG_QUOT     = 32'd119304;
  localparam logic [MUL_W-1:0]     ANG_REM      = 32'd23296;
  localparam int unsigned          REM_W        = 30;
  localparam logic [REM_W-1:0]     HALF_DIV     = 30'd18000;
  // floor(m / 36000) = (m * ceil(2^46 / 36000)) >> 46, exact for m < 2^30
  localparam logic [MUL_W-1:0]     DIV_RECIP    = 32'd1954687339;
  localparam int unsigned          RECIP_SHIFT  = 46;
  localparam int unsigned          QUOT_W       = 15;

  // cordic gain limit, Q30
  localparam logic [MUL_W-1:0] GAIN_Q30   = 32'd652032874;
  localparam int unsigned      GAIN_SHIFT = 14;

  // quadrant fold and result shaping
  localparam logic [ANG_W-1:0]        QUARTER_TURN = 32'h4000_0000;
  localparam logic signed [CX_W:0]    ROUND_BIAS   = 45'sd32768;
  localparam int unsigned             ROUND_SHIFT  = 16;
  localparam logic signed [RND_W-1:0] STEP_LIMIT   = 29'sd16777215;
  localparam logic [THR_W-1:0]        THR_RESET    = 8'd1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_BQ,
    ST_MUL_BR,
    ST_REM_ADD,
    ST_MUL_Q,
    ST_ANGLE,
    ST_LOAD,
    ST_ROTATE,
    ST_ROUND,
    ST_UPDATE
  } cdra_state_e;

  // rotator control from the sequencer
  typedef struct packed {
    logic load;
    logic step;
  } cdra_rot_ctrl_t;

  // arctangent of 2^-i in binary angle units
  function automatic logic [ANG_W-1:0] cdra_atan(input logic [IDX_W-1:0] idx);
    logic [ANG_W-1:0] a;
    case (idx)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      5'd24:   a = 32'h0000_0029;
      5'd25:   a = 32'h0000_0014;
      5'd26:   a = 32'h0000_000A;
      5'd27:   a = 32'h0000_0005;
      5'd28:   a = 32'h0000_0003;
      5'd29:   a = 32'h0000_0001;
      5'd30:   a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

// ----- hdl/cdra_if.sv -----
// ----------------------------------------------------------------------------
// cdra channel interfaces
// Valid/ready channels for movements, results and the threshold register.
// ----------------------------------------------------------------------------

// movement channel
interface cdra_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] bearing;
  logic [23:0] distance;

  modport source (output valid, output bearing, output distance, input ready);
  modport sink   (input valid, input bearing, input distance, output ready);
endinterface

// result channel
interface cdra_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] step_x;
  logic signed [24:0] step_y;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;

  modport source (output valid, output step_x, output step_y, output pos_x_out,
                  output pos_y_out, input ready);
  modport sink   (input valid, input step_x, input step_y, input pos_x_out,
                  input pos_y_out, output ready);
endinterface

// threshold register write channel
interface cdra_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] snap_threshold;

  modport source (output valid, output snap_threshold, input ready);
  modport sink   (input valid, input snap_threshold, output ready);
endinterface

// ----- hdl/cdra_mul.sv -----
// ----------------------------------------------------------------------------
// cdra_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cdra_mul (
  input  logic                        clk_i,
  input  logic [cdra_pkg::MUL_W-1:0]  a_i,
  input  logic [cdra_pkg::MUL_W-1:0]  b_i,
  output logic [cdra_pkg::PROD_W-1:0] p_o
);
  import cdra_pkg::*;

  logic [PROD_W-1:0] p_q;

  // product register
  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- hdl/cdra_rotator.sv -----
// ----------------------------------------------------------------------------
// cdra_rotator
// CORDIC vector registers with one shared shift-add micro-rotation per cycle.
// ----------------------------------------------------------------------------
module cdra_rotator (
  input  logic                              clk_i,
  input  cdra_pkg::cdra_rot_ctrl_t          ctrl_i,
  input  logic [cdra_pkg::IDX_W-1:0]        idx_i,
  input  logic signed [cdra_pkg::CX_W-1:0]  x0_i,
  input  logic signed [cdra_pkg::CZ_W-1:0]  z0_i,
  output logic signed [cdra_pkg::CX_W-1:0]  x_o,
  output logic signed [cdra_pkg::CX_W-1:0]  y_o
);
  import cdra_pkg::*;

  logic signed [CX_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [CZ_W-1:0] z_q, z_d;
  logic signed [CX_W-1:0] xs, ys;
  logic signed [CZ_W-1:0] atan_ext;

  // start vector load, or one micro-rotation toward z = 0
  always_comb begin
    xs       = x_q >>> idx_i;
    ys       = y_q >>> idx_i;
    atan_ext = $signed({{(CZ_W-ANG_W){1'b0}}, cdra_atan(idx_i)});
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    if (ctrl_i.load) begin
      x_d = x0_i;
      y_d = '0;
      z_d = z0_i;
    end else if (ctrl_i.step) begin
      if (!z_q[CZ_W-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_ext;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_ext;
      end
    end
  end

  // vector registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// ----- hdl/cdra_finish.sv -----
// ----------------------------------------------------------------------------
// cdra_finish
// Rounds one CORDIC component to Q16.8, undoes the quadrant fold, clamps the
// step and snaps small magnitudes to zero.
// ----------------------------------------------------------------------------
module cdra_finish (
  input  logic signed [cdra_pkg::CX_W-1:0]   v_i,
  input  logic                               flip_i,
  input  logic [cdra_pkg::THR_W-1:0]         thr_i,
  output logic signed [cdra_pkg::STEP_W-1:0] step_o
);
  import cdra_pkg::*;

  logic signed [CX_W:0]    rnd;
  logic signed [CX_W:0]    rnd_sh;
  logic signed [RND_W-1:0] c, c_neg, c_clamp, mag;

  always_comb begin
    // round half up, then drop 16 fraction bits
    rnd    = $signed({v_i[CX_W-1], v_i}) + ROUND_BIAS;
    rnd_sh = rnd >>> ROUND_SHIFT;
    c      = rnd_sh[RND_W-1:0];
    c_neg  = flip_i ? -c : c;
    // clamp to the step range
    if (c_neg < -STEP_LIMIT) begin
      c_clamp = -STEP_LIMIT;
    end else if (c_neg > STEP_LIMIT) begin
      c_clamp = STEP_LIMIT;
    end else begin
      c_clamp = c_neg;
    end
    // snap on magnitude
    mag = c_clamp[RND_W-1] ? -c_clamp : c_clamp;
    if (mag <= $signed({{(RND_W-THR_W){1'b0}}, thr_i})) begin
      step_o = '0;
    end else begin
      step_o = c_clamp[STEP_W-1:0];
    end
  end

endmodule

// ----- hdl/compass_dead_reckoning_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// compass_dead_reckoning_accumulator_core
// Dead-reckoning tracker: bearing and distance to a rectangular step through
// a CORDIC rotation, added to saturating Q24.8 position accumulators.
// ----------------------------------------------------------------------------
// Each movement passes from its input transfer through the setup states,
// the rotation and the round and update states to a valid result; a new
// movement is accepted only in the idle state, entered as the result is
// registered. The setup states MUL_BQ, MUL_BR, REM_ADD, MUL_Q, ANGLE and
// LOAD prepare the angle and start vector through one shared 32x32
// multiplier (bearing to binary angle by reciprocal multiplication, distance
// times the CORDIC gain), one micro-rotation per cycle follows on the
// shared shift-add unit, and the round and update states round, snap and
// accumulate. A finished result waits in the output register while the next
// movement is taken in; the next result is held in the update step until
// that one is transferred. The threshold register resets to 1 and is
// written through its own channel, which is always ready.
module compass_dead_reckoning_accumulator_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cdra_in_if.sink          in_i,
  cdra_out_if.source       out_o,
  cdra_cfg_if.sink         cfg_i
);
  import cdra_pkg::*;

  cdra_state_e state_q, state_d;

  logic [THR_W-1:0]      thr_q;
  logic [BEARING_W-1:0]  b_q;
  logic [DIST_W-1:0]     r_q;
  logic [ANG_W-1:0]      bq_q;
  logic [REM_W-1:0]      rem_q;
  logic                  flip_q;
  logic signed [CZ_W-1:0] z0_q;
  logic [IDX_W-1:0]      idx_q;
  logic signed [STEP_W-1:0] sx_q, sy_q;
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
  logic                  out_valid_q;
  logic signed [STEP_W-1:0] out_sx_q, out_sy_q;

  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0]     prod;
  cdra_rot_ctrl_t        rot_ctrl;
  logic signed [CX_W-1:0] rot_x, rot_y, x0;
  logic signed [STEP_W-1:0] fin_x, fin_y;

  logic                  in_xfer;
  logic                  out_load;
  logic [BEARING_W-1:0]  b_wrap;
  logic [ANG_W-1:0]      phi, phi_adj, phi_quarter;
  logic                  flip;
  logic signed [POS_W:0] sum_x, sum_y;
  logic signed [POS_W-1:0] pos_x_new, pos_y_new;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // bearing wraps once
  assign b_wrap = (in_i.bearing >= BEARING_WRAP) ? in_i.bearing - BEARING_WRAP
                                                 : in_i.bearing;

  // binary angle and quadrant fold
  assign phi         = bq_q + ANG_W'(prod[RECIP_SHIFT +: QUOT_W]);
  assign phi_quarter = phi + QUARTER_TURN;
  assign flip        = phi_quarter[ANG_W-1];
  assign phi_adj     = {phi[ANG_W-1] ^ flip, phi[ANG_W-2:0]};

  // start vector from the gain product
  assign x0 = $signed({{(CX_W-X0_W){1'b0}}, prod[GAIN_SHIFT +: X0_W]});

  // saturating accumulation
  always_comb begin
    sum_x = $signed({pos_x_q[POS_W-1], pos_x_q})
          + $signed({{(POS_W+1-STEP_W){sx_q[STEP_W-1]}}, sx_q});
    sum_y = $signed({pos_y_q[POS_W-1], pos_y_q})
          + $signed({{(POS_W+1-STEP_W){sy_q[STEP_W-1]}}, sy_q});
    if (sum_x[POS_W] != sum_x[POS_W-1]) begin
      pos_x_new = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_x_new = sum_x[POS_W-1:0];
    end
    if (sum_y[POS_W] != sum_y[POS_W-1]) begin
      pos_y_new = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_y_new = sum_y[POS_W-1:0];
    end
  end

  // sequencer next state and unit control
  always_comb begin
    state_d  = state_q;
    mul_a    = '0;
    mul_b    = '0;
    rot_ctrl = '0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_MUL_BQ;
      end
      ST_MUL_BQ: begin
        mul_a   = MUL_W'(b_q);
        mul_b   = ANG_QUOT;
        state_d = ST_MUL_BR;
      end
      ST_MUL_BR: begin
        mul_a   = MUL_W'(b_q);
        mul_b   = ANG_REM;
        state_d = ST_REM_ADD;
      end
      ST_REM_ADD: begin
        state_d = ST_MUL_Q;
      end
      ST_MUL_Q: begin
        mul_a   = MUL_W'(rem_q);
        mul_b   = DIV_RECIP;
        state_d = ST_ANGLE;
      end
      ST_ANGLE: begin
        mul_a   = MUL_W'(r_q);
        mul_b   = GAIN_Q30;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        rot_ctrl.load = 1'b1;
        state_d       = ST_ROTATE;
      end
      ST_ROTATE: begin
        rot_ctrl.step = 1'b1;
        if (idx_q == IDX_W'(CORDIC_STAGES - 1)) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers: threshold, position, output valid, stage index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_RESET;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) thr_q <= cfg_i.snap_threshold;
      if (out_load) begin
        pos_x_q     <= pos_x_new;
        pos_y_q     <= pos_y_new;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_LOAD) begin
        idx_q <= '0;
      end else if (state_q == ST_ROTATE) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      b_q <= b_wrap;
      r_q <= in_i.distance;
    end
    if (state_q == ST_MUL_BR) bq_q <= prod[ANG_W-1:0];
    if (state_q == ST_REM_ADD) rem_q <= prod[REM_W-1:0] + HALF_DIV;
    if (state_q == ST_ANGLE) begin
      flip_q <= flip;
      z0_q   <= $signed({{(CZ_W-ANG_W){phi_adj[ANG_W-1]}}, phi_adj});
    end
    if (state_q == ST_ROUND) begin
      sx_q <= fin_x;
      sy_q <= fin_y;
    end
    if (out_load) begin
      out_sx_q <= sx_q;
      out_sy_q <= sy_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.step_x    = out_sx_q;
  assign out_o.step_y    = out_sy_q;
  assign out_o.pos_x_out = pos_x_q;
  assign out_o.pos_y_out = pos_y_q;

  // shared multiplier
  cdra_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // shift-add rotation unit
  cdra_rotator u_rotator (
    .clk_i  (clk_i),
    .ctrl_i (rot_ctrl),
    .idx_i  (idx_q),
    .x0_i   (x0),
    .z0_i   (z0_q),
    .x_o    (rot_x),
    .y_o    (rot_y)
  );

  // east from the sine leg, north from the cosine leg
  cdra_finish u_finish_x (
    .v_i    (rot_y),
    .flip_i (flip_q),
    .thr_i  (thr_q),
    .step_o (fin_x)
  );

  cdra_finish u_finish_y (
    .v_i    (rot_x),
    .flip_i (flip_q),
    .thr_i  (thr_q),
    .step_o (fin_y)
  );

  // a movement transfer closes the input until its result is registered
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_i.ready)
    else $error("input ready right after a movement transfer");

  // the stage index never runs past the configured stage count
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROTATE) |-> (idx_q <= IDX_W'(CORDIC_STAGES - 1)))
    else $error("cordic stage index out of range");

  // a new result appears only out of the update step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> ($past(state_q) == ST_UPDATE))
    else $error("result valid raised outside the update step");

  // position only moves when a result is loaded
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> ($stable(pos_x_q) && $stable(pos_y_q)))
    else $error("position changed without a result");

endmodule

// ----- verif/dead_reckoning_checker.sv -----
// ----------------------------------------------------------------------------
// dead_reckoning_checker
// Watches the movement, result and threshold channels of the dead-reckoning
// accumulator. Predicts each step and position with its own CORDIC model and
// compares the results in order, counting every mismatch.
// ----------------------------------------------------------------------------
module dead_reckoning_checker
  import cdra_pkg::*;
#(
  parameter int unsigned ROTATION_STAGES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  cdra_in_if   move_ch,
  cdra_out_if  result_ch,
  cdra_cfg_if  thr_ch,
  output int   mismatch_count_o,
  output int   outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // angle conversion, gain and limits
  localparam longint unsigned FULL_TURN    = 64'd36000;
  localparam longint unsigned HALF_TURN    = 64'd18000;
  localparam longint unsigned VECTOR_GAIN  = 64'd652032874;  // 0.607252935 in Q30
  localparam int unsigned     GAIN_DROP    = 14;
  localparam longint          ROUND_HALF   = 64'sd32768;
  localparam longint          STEP_MAX     = 64'sd16777215;
  localparam longint          POS_HI       = 64'sd2147483647;
  localparam longint          POS_LO       = -64'sd2147483648;
  localparam logic [THR_W-1:0] SNAP_AFTER_RESET = 8'd1;

  // arctangent of 2^-i, full circle = 2^32
  localparam longint ATAN_LUT [32] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
    'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
    'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D,
    'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
    'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
    'h00000029, 'h00000014, 'h0000000A, 'h00000005,
    'h00000003, 'h00000001, 'h00000001, 'h00000000
  };

  typedef struct packed {
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
  } movement_result_t;

  movement_result_t predicted_q[$];
  longint           east_pos;
  longint           north_pos;
  logic [THR_W-1:0] snap_thr;
  int               mismatches;

  // round to Q16.8, undo the half-turn fold, clamp, then snap small values
  function automatic longint shape_component(input longint v, input bit flip);
    longint c;
    c = (v + ROUND_HALF) >>> 16;
    if (flip) c = -c;
    if (c > STEP_MAX) c = STEP_MAX;
    else if (c < -STEP_MAX) c = -STEP_MAX;
    if ((c < 0 ? -c : c) <= longint'(snap_thr)) c = 0;
    return c;
  endfunction

  function automatic longint saturate_pos(input longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  // one movement: bearing to binary angle, rotate, shape, accumulate
  function automatic movement_result_t rotate_and_accumulate(
    input logic [BEARING_W-1:0] bearing,
    input logic [DIST_W-1:0]    distance
  );
    longint unsigned  b;
    longint unsigned  angle_wide;
    logic [31:0]      phi;
    logic [31:0]      shifted;
    bit               flip;
    longint           x, y, z, xs, ys, sx, sy;
    movement_result_t res;
    b = 64'(bearing);
    if (b >= FULL_TURN) b = b - FULL_TURN;
    angle_wide = ((b << 32) + HALF_TURN) / FULL_TURN;
    phi = angle_wide[31:0];
    // bearings in the back half are folded by a half turn
    shifted = phi + 32'h4000_0000;
    flip = shifted[31];
    if (flip) phi = phi + 32'h8000_0000;
    z = longint'(signed'(phi));
    x = longint'((64'(distance) * VECTOR_GAIN) >> GAIN_DROP);
    y = 0;
    for (int i = 0; i < ROTATION_STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_LUT[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_LUT[i];
      end
    end
    sx = shape_component(y, flip);
    sy = shape_component(x, flip);
    east_pos  = saturate_pos(east_pos + sx);
    north_pos = saturate_pos(north_pos + sy);
    res.step_x = STEP_W'(sx);
    res.step_y = STEP_W'(sy);
    res.pos_x  = POS_W'(east_pos);
    res.pos_y  = POS_W'(north_pos);
    return res;
  endfunction

  task automatic report_field(input string field, input longint want, input longint got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // compare results, then track register writes and new movements
  always @(posedge clk_i or negedge rst_ni) begin
    movement_result_t want;
    if (!rst_ni) begin
      predicted_q.delete();
      east_pos   = 0;
      north_pos  = 0;
      snap_thr   = SNAP_AFTER_RESET;
      mismatches = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer mismatch, expected none, actual step_x %0d",
                   $time, result_ch.step_x);
        end else begin
          want = predicted_q.pop_front();
          if (result_ch.step_x !== want.step_x)
            report_field("step_x", want.step_x, result_ch.step_x);
          if (result_ch.step_y !== want.step_y)
            report_field("step_y", want.step_y, result_ch.step_y);
          if (result_ch.pos_x_out !== want.pos_x)
            report_field("pos_x_out", want.pos_x, result_ch.pos_x_out);
          if (result_ch.pos_y_out !== want.pos_y)
            report_field("pos_y_out", want.pos_y, result_ch.pos_y_out);
        end
      end
      if (thr_ch.valid && thr_ch.ready)
        snap_thr = thr_ch.snap_threshold;
      if (move_ch.valid && move_ch.ready)
        predicted_q.insert(predicted_q.size(),
                           rotate_and_accumulate(move_ch.bearing, move_ch.distance));
    end
    outstanding_o    <= predicted_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives movements and threshold writes into the dead-reckoning accumulator
// with random gaps and result stalls, directed corner cases first, then
// random patterns over several threshold settings. The checker does the
// prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  import cdra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STAGES       = 16;
  localparam int          NUM_PHASES   = 5;
  localparam int          PHASE_MOVES  = 120;
  localparam int          SETTLE_CYCLES = 60;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          NUM_DIRECTED = 22;

  // directed movements: cardinal points, fold boundaries, wrap, tiny and huge
  localparam logic [BEARING_W-1:0] DIR_BEARING [NUM_DIRECTED] = '{
    16'd0,     16'd9000,  16'd18000, 16'd27000, 16'd35999, 16'd4500,
    16'd8999,  16'd9001,  16'd26999, 16'd27001, 16'd36000, 16'd65535,
    16'd45000, 16'd13500, 16'd22500, 16'd31500, 16'd0,     16'd0,
    16'd0,     16'd17999, 16'd1,     16'd35000
  };
  localparam logic [DIST_W-1:0] DIR_DISTANCE [NUM_DIRECTED] = '{
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1000,
    24'd256,    24'd256,    24'd256,    24'd256,    24'd256,    24'hFFFFFF,
    24'd5000,   24'd0,      24'd1,      24'd2,      24'd1,      24'd2,
    24'd3,      24'd800000, 24'hFFFFFF, 24'd123456
  };
  localparam int NUM_EDGES = 10;
  localparam logic [BEARING_W-1:0] EDGE_BEARING [NUM_EDGES] = '{
    16'd0, 16'd8999, 16'd9000, 16'd9001, 16'd17999,
    16'd18000, 16'd26999, 16'd27000, 16'd27001, 16'd35999
  };

  typedef enum logic [2:0] {
    PAT_MARCH,
    PAT_UNIFORM,
    PAT_SHORT,
    PAT_WRAP,
    PAT_EDGE,
    PAT_BITS
  } move_pattern_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   mismatch_count;
  int   outstanding;

  cdra_in_if  move_ch ();
  cdra_out_if result_ch ();
  cdra_cfg_if thr_ch ();

  compass_dead_reckoning_accumulator_core #(
    .CORDIC_STAGES (STAGES)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (move_ch),
    .out_o  (result_ch),
    .cfg_i  (thr_ch)
  );

  dead_reckoning_checker #(
    .ROTATION_STAGES (STAGES)
  ) checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .move_ch          (move_ch),
    .result_ch        (result_ch),
    .thr_ch           (thr_ch),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: runs of ready broken by stalls, some long stall-free stretches
  initial begin
    int run;
    int stall;
    result_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      result_ch.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // one movement transfer, then an optional gap
  task automatic send_movement(input logic [BEARING_W-1:0] bearing,
                               input logic [DIST_W-1:0] distance);
    int gap;
    move_ch.valid    <= 1'b1;
    move_ch.bearing  <= bearing;
    move_ch.distance <= distance;
    @(posedge clk);
    while (!move_ch.ready) @(posedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      move_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every predicted result to arrive
  task automatic wait_idle();
    move_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    thr_ch.valid          <= 1'b1;
    thr_ch.snap_threshold <= value;
    @(posedge clk);
    while (!thr_ch.ready) @(posedge clk);
    thr_ch.valid <= 1'b0;
  endtask

  // random segments: long marches drive the accumulators into saturation
  task automatic run_random_moves(input int count);
    int                   left;
    int                   seg;
    int                   r;
    int                   heading;
    int                   h;
    move_pattern_e        pattern;
    logic [BEARING_W-1:0] b;
    logic [DIST_W-1:0]    d;
    left = count;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 40)      pattern = PAT_MARCH;
      else if (r < 60) pattern = PAT_UNIFORM;
      else if (r < 70) pattern = PAT_SHORT;
      else if (r < 80) pattern = PAT_WRAP;
      else if (r < 90) pattern = PAT_EDGE;
      else             pattern = PAT_BITS;
      seg = (pattern == PAT_MARCH) ? $urandom_range(60, 200) : $urandom_range(5, 30);
      if (seg > left) seg = left;
      heading = 9000 * int'($urandom_range(0, 3));
      repeat (seg) begin
        case (pattern)
          PAT_MARCH: begin
            h = heading + int'($urandom_range(0, 400)) - 200;
            if (h < 0) h = h + 36000;
            if (h >= 36000) h = h - 36000;
            b = BEARING_W'(h);
            d = DIST_W'($urandom_range(24'hC00000, 24'hFFFFFF));
          end
          PAT_UNIFORM: begin
            b = BEARING_W'($urandom_range(0, 35999));
            d = DIST_W'($urandom);
          end
          PAT_SHORT: begin
            b = BEARING_W'($urandom_range(0, 35999));
            d = DIST_W'($urandom_range(0, 700));
          end
          PAT_WRAP: begin
            b = BEARING_W'($urandom_range(36000, 65535));
            d = DIST_W'($urandom);
          end
          PAT_EDGE: begin
            b = EDGE_BEARING[$urandom_range(0, NUM_EDGES - 1)];
            d = ($urandom_range(0, 1) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(0, 600));
          end
          default: begin
            b = BEARING_W'($urandom);
            d = DIST_W'(1) << $urandom_range(0, DIST_W - 1);
            if ($urandom_range(0, 1) == 0) d = ~d;
          end
        endcase
        send_movement(b, d);
        left--;
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [THR_W-1:0] phase_thr [NUM_PHASES];
    phase_thr[0] = 8'd1;
    phase_thr[1] = 8'd0;
    phase_thr[2] = 8'd255;
    phase_thr[3] = THR_W'($urandom_range(2, 254));
    phase_thr[4] = THR_W'($urandom_range(0, 15));
    move_ch.valid         <= 1'b0;
    move_ch.bearing       <= '0;
    move_ch.distance      <= '0;
    thr_ch.valid          <= 1'b0;
    thr_ch.snap_threshold <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at the reset threshold
    for (int k = 0; k < NUM_DIRECTED; k++)
      send_movement(DIR_BEARING[k], DIR_DISTANCE[k]);

    // random phases, threshold changed only while idle
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_idle();
        write_threshold(phase_thr[p]);
      end
      run_random_moves(PHASE_MOVES);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
